>>> hdl/dpw_pkg.sv
// Shared types, constants and helpers for the depth pixel to world point block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpw_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int CNT_W       = 12;
    localparam int LIM_W       = 13;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int ACC_W       = 58;
    localparam int STEP_W      = 5;
    localparam int CFG_IDX_W   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DSCALE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_QUAT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_TRANS  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 4'd7;

    // sequencer steps of the back end
    localparam logic [STEP_W-1:0] ST_Z_DONE   = 5'd10;
    localparam logic [STEP_W-1:0] ST_LAST     = 5'd23;

    typedef struct packed {
        logic [15:0] depth_raw;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_start;
    } t_pix_in;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         point_red;
        logic [7:0]         point_green;
        logic [7:0]         point_blue;
    } t_point_out;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [15:0]      depth;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_job;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [23:0] inv_depth_scale;
        logic [63:0] pose_quaternion;
        logic [62:0] pose_translation;
        logic [12:0] image_width;
    } t_cfg;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_HOLD
    } t_bstate;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh000000007fffffff) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sh0000000080000000) begin
            res = -32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/dpw_fifo.sv
// Short job queue between the pixel front end and the arithmetic back end.
// Depends on dpw_pkg (t_job, FIFO_DEPTH).
`default_nettype none

module dpw_fifo
    import dpw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW:0]   r_wp, n_wp;
    logic [FIFO_AW:0]   r_rp, n_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[FIFO_AW] != r_rp[FIFO_AW]) &&
                     (r_wp[FIFO_AW-1:0] == r_rp[FIFO_AW-1:0]);
    assign o_job   = r_mem[r_rp[FIFO_AW-1:0]];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push && !o_full) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rp = r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp[FIFO_AW-1:0]] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dpw_front.sv
// Pixel front end: column/row counting and zero-depth filtering.
// Depends on dpw_pkg; feeds dpw_fifo.
`default_nettype none

module dpw_front
    import dpw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_pix_in     i_pix,
    input  wire logic [12:0] i_image_width,
    input  wire logic        i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output t_job             o_job
);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] u_cur, v_cur;
    logic [LIM_W-1:0] lim, col_inc, row_inc;
    logic             accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        u_cur = i_pix.frame_start ? '0 : r_col;
        v_cur = i_pix.frame_start ? '0 : r_row;
        if (i_image_width == '0 || i_image_width > LIM_W'(MAX_WIDTH)) begin
            lim = LIM_W'(MAX_WIDTH);
        end else begin
            lim = i_image_width;
        end
        col_inc = {1'b0, u_cur} + 1'b1;
        row_inc = {1'b0, v_cur} + 1'b1;
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            n_col = col_inc[CNT_W-1:0];
            n_row = v_cur;
            if (col_inc >= lim) begin
                n_col = '0;
                n_row = (row_inc >= LIM_W'(MAX_HEIGHT)) ? '0 : row_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push      = accept && (i_pix.depth_raw != '0);
    assign o_job.col   = u_cur;
    assign o_job.row   = v_cur;
    assign o_job.depth = i_pix.depth_raw;
    assign o_job.red   = i_pix.red;
    assign o_job.green = i_pix.green;
    assign o_job.blue  = i_pix.blue;

endmodule

`default_nettype wire

>>> hdl/dpw_back.sv
// Arithmetic back end: one shared 33x33 multiplier stepped by a sequencer,
// then an output register. Depends on dpw_pkg.
`default_nettype none

module dpw_back
    import dpw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_job  i_job,
    input  wire logic  i_q_empty,
    output logic       o_pop,
    output logic       o_valid,
    output t_point_out o_data,
    input  wire logic  i_stall
);

    t_bstate            r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    t_job               r_job;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_q [9];
    logic signed [21:0] r_rot [9];
    logic signed [31:0] r_z, r_px, r_py;
    logic signed [29:0] r_rayx, r_rayy;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_w [3];
    logic               r_ovalid;
    t_point_out         r_out;
    logic               load_out;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [17:0] offx, offy;
    logic signed [20:0] tsel;
    logic signed [ACC_W-1:0] acc_base, acc_sum;
    logic signed [65:0] pr12, pr16;
    logic [40:0]        zr;
    logic signed [34:0] qe [9];
    logic signed [34:0] rfull [9];
    logic signed [34:0] rrnd [9];
    logic [STEP_W-1:0]  cstep;

    assign qw = i_cfg.pose_quaternion[63:48];
    assign qx = i_cfg.pose_quaternion[47:32];
    assign qy = i_cfg.pose_quaternion[31:16];
    assign qz = i_cfg.pose_quaternion[15:0];
    assign offx = $signed({2'b00, r_job.col, 4'b0000}) - $signed({2'b00, i_cfg.center_x});
    assign offy = $signed({2'b00, r_job.row, 4'b0000}) - $signed({2'b00, i_cfg.center_y});

    // issue: operands of the step
    always_comb begin
        case (r_step)
            5'd0:  begin mul_a = 33'(qy);  mul_b = 33'(qy); end
            5'd1:  begin mul_a = 33'(qz);  mul_b = 33'(qz); end
            5'd2:  begin mul_a = 33'(qx);  mul_b = 33'(qx); end
            5'd3:  begin mul_a = 33'(qx);  mul_b = 33'(qy); end
            5'd4:  begin mul_a = 33'(qx);  mul_b = 33'(qz); end
            5'd5:  begin mul_a = 33'(qy);  mul_b = 33'(qz); end
            5'd6:  begin mul_a = 33'(qw);  mul_b = 33'(qx); end
            5'd7:  begin mul_a = 33'(qw);  mul_b = 33'(qy); end
            5'd8:  begin mul_a = 33'(qw);  mul_b = 33'(qz); end
            5'd9:  begin
                mul_a = $signed({17'd0, r_job.depth});
                mul_b = $signed({9'd0, i_cfg.inv_depth_scale});
            end
            5'd10: begin mul_a = 33'(offx); mul_b = $signed({9'd0, i_cfg.inv_focal_x}); end
            5'd11: begin mul_a = 33'(offy); mul_b = $signed({9'd0, i_cfg.inv_focal_y}); end
            5'd12: begin mul_a = 33'(r_rayx); mul_b = 33'(r_z); end
            5'd13: begin mul_a = 33'(r_rayy); mul_b = 33'(r_z); end
            5'd14: begin mul_a = 33'(r_rot[0]); mul_b = 33'(r_px); end
            5'd15: begin mul_a = 33'(r_rot[1]); mul_b = 33'(r_py); end
            5'd16: begin mul_a = 33'(r_rot[2]); mul_b = 33'(r_z);  end
            5'd17: begin mul_a = 33'(r_rot[3]); mul_b = 33'(r_px); end
            5'd18: begin mul_a = 33'(r_rot[4]); mul_b = 33'(r_py); end
            5'd19: begin mul_a = 33'(r_rot[5]); mul_b = 33'(r_z);  end
            5'd20: begin mul_a = 33'(r_rot[6]); mul_b = 33'(r_px); end
            5'd21: begin mul_a = 33'(r_rot[7]); mul_b = 33'(r_py); end
            5'd22: begin mul_a = 33'(r_rot[8]); mul_b = 33'(r_z);  end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // rotation entries from the stored quaternion products
    // r_q order: yy zz xx xy xz yz wx wy wz
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            qe[k] = 35'(r_q[k]);
        end
        rfull[0] = 35'sh10000000 - 2 * (qe[0] + qe[1]);
        rfull[1] = 2 * (qe[3] - qe[8]);
        rfull[2] = 2 * (qe[4] + qe[7]);
        rfull[3] = 2 * (qe[3] + qe[8]);
        rfull[4] = 35'sh10000000 - 2 * (qe[2] + qe[1]);
        rfull[5] = 2 * (qe[5] - qe[6]);
        rfull[6] = 2 * (qe[4] - qe[7]);
        rfull[7] = 2 * (qe[5] + qe[6]);
        rfull[8] = 35'sh10000000 - 2 * (qe[2] + qe[0]);
        for (int k = 0; k < 9; k++) begin
            rrnd[k] = rfull[k] + 35'sd2048;
        end
    end

    // consume: result of the previous step
    assign cstep = r_step - 1'b1;
    assign pr12  = r_prod + 66'sd2048;
    assign pr16  = r_prod + 66'sd32768;
    assign zr    = {1'b0, r_prod[39:0]} + 41'd128;

    always_comb begin
        case (cstep)
            5'd14:   tsel = i_cfg.pose_translation[62:42];
            5'd17:   tsel = i_cfg.pose_translation[41:21];
            default: tsel = i_cfg.pose_translation[20:0];
        endcase
        // translation in Q.32 plus the rounding half
        acc_base = $signed({{15{tsel[20]}}, tsel, 22'd0}) + ACC_W'(32768);
        if (cstep == 5'd14 || cstep == 5'd17 || cstep == 5'd20) begin
            acc_sum = acc_base + r_prod[ACC_W-1:0];
        end else begin
            acc_sum = r_acc + r_prod[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_RUN) begin
            if (r_step >= 5'd1 && r_step <= 5'd9) begin
                r_q[cstep[3:0]] <= r_prod[31:0];
            end
            if (r_step == ST_Z_DONE) begin
                r_z <= (zr[40:39] != 2'b00) ? 32'sh7fffffff : $signed(zr[39:8]);
                for (int k = 0; k < 9; k++) begin
                    r_rot[k] <= rrnd[k][33:12];
                end
            end
            if (r_step == 5'd11) r_rayx <= pr12[41:12];
            if (r_step == 5'd12) r_rayy <= pr12[41:12];
            if (r_step == 5'd13) r_px <= sat32({{14{pr16[65]}}, pr16[65:16]});
            if (r_step == 5'd14) r_py <= sat32({{14{pr16[65]}}, pr16[65:16]});
            if (r_step >= 5'd15) r_acc <= acc_sum;
            if (r_step == 5'd17) r_w[0] <= sat32({{22{acc_sum[ACC_W-1]}}, acc_sum[ACC_W-1:16]});
            if (r_step == 5'd20) r_w[1] <= sat32({{22{acc_sum[ACC_W-1]}}, acc_sum[ACC_W-1:16]});
            if (r_step == ST_LAST) r_w[2] <= sat32({{22{acc_sum[ACC_W-1]}}, acc_sum[ACC_W-1:16]});
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_step  = '0;
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == ST_LAST) begin
                    n_state = B_HOLD;
                end
            end
            B_HOLD: begin
                if (!r_ovalid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_out.world_x     <= r_w[0];
            r_out.world_y     <= r_w[1];
            r_out.world_z     <= r_w[2];
            r_out.point_red   <= r_job.red;
            r_out.point_green <= r_job.green;
            r_out.point_blue  <= r_job.blue;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE))
        else $error("queue popped while a job is in progress");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN) |-> (r_step <= ST_LAST))
        else $error("sequencer step overran");

    a_load_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> $past(r_state == B_RUN) || $past(r_state == B_HOLD))
        else $error("output loaded without a finished job");

endmodule

`default_nettype wire

>>> hdl/depth_pixel_to_world_point_top.sv
// Top level of the depth pixel to world point block: configuration registers,
// front end, job queue and back end. Depends on dpw_pkg, dpw_front, dpw_fifo, dpw_back.
//
//  channel | direction | handshake                 | payload
//  pixel   | in        | i_in_valid / o_in_stall   | i_in_data  (t_pix_in)
//  point   | out       | o_out_valid / i_out_stall | o_out_data (t_point_out)
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A zero-depth pixel is dropped in the front end and makes no point.
// A valid pixel takes 24 sequencer steps in the back end around the
// single shared multiplier, plus queue pop and output load.
// The four-entry queue lets the front keep accepting while the back works.
// Reset is synchronous, active low; config registers return to their defaults.
`default_nettype none

module depth_pixel_to_world_point_top
    import dpw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_pix_in              i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_point_out                o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    t_cfg   r_cfg;
    t_job   front_job, q_job;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x         <= 16'd5208;
            r_cfg.center_y         <= 16'd4056;
            r_cfg.inv_focal_x      <= 24'd32389;
            r_cfg.inv_focal_y      <= 24'd32326;
            r_cfg.inv_depth_scale  <= 24'd16777;
            r_cfg.pose_quaternion  <= 64'h4000_0000_0000_0000;
            r_cfg.pose_translation <= '0;
            r_cfg.image_width      <= 13'd640;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_cfg.center_x         <= i_cfg_data[15:0];
                CFG_CENTER_Y:    r_cfg.center_y         <= i_cfg_data[15:0];
                CFG_INV_FOCAL_X: r_cfg.inv_focal_x      <= i_cfg_data[23:0];
                CFG_INV_FOCAL_Y: r_cfg.inv_focal_y      <= i_cfg_data[23:0];
                CFG_INV_DSCALE:  r_cfg.inv_depth_scale  <= i_cfg_data[23:0];
                CFG_POSE_QUAT:   r_cfg.pose_quaternion  <= i_cfg_data;
                CFG_POSE_TRANS:  r_cfg.pose_translation <= i_cfg_data[62:0];
                CFG_IMAGE_WIDTH: r_cfg.image_width      <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    dpw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_pix         (i_in_data),
        .i_image_width (r_cfg.image_width),
        .i_q_full      (q_full),
        .o_stall       (o_in_stall),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    dpw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dpw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_job     (q_job),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data),
        .i_stall   (i_out_stall)
    );

endmodule

`default_nettype wire

>>> tb/dpw_checker.sv
// Scoreboard for the depth pixel to world point block: tracks the config writes,
// predicts one world point per nonzero-depth pixel request and compares the outputs.
// Depends on dpw_pkg only.
`default_nettype none

module dpw_checker
    import dpw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire t_pix_in              i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_point_out           i_out_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg       regs;
    int         col_cnt;
    int         row_cnt;
    t_point_out points_due[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // round half up at bit n, floor on the 64-bit wrapped sum
    function automatic longint rnd(input longint v, input int n);
        longint t;
        t = v + (64'sd1 <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sx(input logic [63:0] v, input int w);
        longint t;
        t = longint'(v << (64 - w));
        return t >>> (64 - w);
    endfunction

    function automatic longint cam_axis(input int pix, input longint centre,
                                        input longint invf, input longint z);
        longint off;
        longint ray;
        off = longint'(pix) * 16 - centre;
        ray = rnd(off * invf, 12);
        return clip32(rnd(ray * z, 16));
    endfunction

    task automatic project_pixel(input t_pix_in px);
        int         u;
        int         v;
        int         lim;
        longint     p[3];
        longint     tr[3];
        longint     r[9];
        longint     qw, qx, qy, qz, acc;
        t_point_out pt;
        if (px.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        u = col_cnt;
        v = row_cnt;
        lim = int'(regs.image_width);
        if (lim == 0 || lim > MAX_WIDTH) lim = MAX_WIDTH;
        col_cnt = u + 1;
        if (col_cnt >= lim) begin
            col_cnt = 0;
            row_cnt = v + 1;
            if (row_cnt >= MAX_HEIGHT) row_cnt = 0;
        end
        if (px.depth_raw != 0) begin
            p[2] = clip32(rnd(longint'(px.depth_raw) * longint'(regs.inv_depth_scale), 8));
            p[0] = cam_axis(u, longint'(regs.center_x), longint'(regs.inv_focal_x), p[2]);
            p[1] = cam_axis(v, longint'(regs.center_y), longint'(regs.inv_focal_y), p[2]);
            qw = sx(regs.pose_quaternion[63:48], 16);
            qx = sx(regs.pose_quaternion[47:32], 16);
            qy = sx(regs.pose_quaternion[31:16], 16);
            qz = sx(regs.pose_quaternion[15:0], 16);
            r[0] = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
            r[1] = 2 * (qx * qy - qw * qz);
            r[2] = 2 * (qx * qz + qw * qy);
            r[3] = 2 * (qx * qy + qw * qz);
            r[4] = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
            r[5] = 2 * (qy * qz - qw * qx);
            r[6] = 2 * (qx * qz - qw * qy);
            r[7] = 2 * (qy * qz + qw * qx);
            r[8] = (64'sd1 <<< 28) - 2 * (qx * qx + qy * qy);
            for (int i = 0; i < 9; i++) r[i] = rnd(r[i], 12);
            tr[0] = sx(64'(regs.pose_translation[62:42]), 21);
            tr[1] = sx(64'(regs.pose_translation[41:21]), 21);
            tr[2] = sx(64'(regs.pose_translation[20:0]), 21);
            acc = r[0] * p[0] + r[1] * p[1] + r[2] * p[2] + tr[0] * (64'sd1 <<< 22);
            pt.world_x = 32'(clip32(rnd(acc, 16)));
            acc = r[3] * p[0] + r[4] * p[1] + r[5] * p[2] + tr[1] * (64'sd1 <<< 22);
            pt.world_y = 32'(clip32(rnd(acc, 16)));
            acc = r[6] * p[0] + r[7] * p[1] + r[8] * p[2] + tr[2] * (64'sd1 <<< 22);
            pt.world_z = 32'(clip32(rnd(acc, 16)));
            pt.point_red   = px.red;
            pt.point_green = px.green;
            pt.point_blue  = px.blue;
            points_due = {points_due, pt};
        end
    endtask

    task automatic check_point(input t_point_out got);
        t_point_out want;
        if (points_due.size() == 0) begin
            $display("%0t: unexpected point %h", $time, got);
            o_errors++;
        end else begin
            want = points_due.pop_front();
            if (got.world_x != want.world_x) begin
                $display("%0t: world_x expected %0d got %0d", $time, want.world_x, got.world_x);
                o_errors++;
            end
            if (got.world_y != want.world_y) begin
                $display("%0t: world_y expected %0d got %0d", $time, want.world_y, got.world_y);
                o_errors++;
            end
            if (got.world_z != want.world_z) begin
                $display("%0t: world_z expected %0d got %0d", $time, want.world_z, got.world_z);
                o_errors++;
            end
            if (got.point_red != want.point_red) begin
                $display("%0t: red expected %0d got %0d", $time, want.point_red, got.point_red);
                o_errors++;
            end
            if (got.point_green != want.point_green) begin
                $display("%0t: green expected %0d got %0d", $time, want.point_green,
                         got.point_green);
                o_errors++;
            end
            if (got.point_blue != want.point_blue) begin
                $display("%0t: blue expected %0d got %0d", $time, want.point_blue,
                         got.point_blue);
                o_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.center_x         = 16'd5208;
            regs.center_y         = 16'd4056;
            regs.inv_focal_x      = 24'd32389;
            regs.inv_focal_y      = 24'd32326;
            regs.inv_depth_scale  = 24'd16777;
            regs.pose_quaternion  = 64'h4000_0000_0000_0000;
            regs.pose_translation = '0;
            regs.image_width      = 13'd640;
            col_cnt = 0;
            row_cnt = 0;
            points_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_point(i_out_data);
            if (i_in_valid && !i_in_stall) project_pixel(i_in_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X:    regs.center_x         = i_cfg_data[15:0];
                    CFG_CENTER_Y:    regs.center_y         = i_cfg_data[15:0];
                    CFG_INV_FOCAL_X: regs.inv_focal_x      = i_cfg_data[23:0];
                    CFG_INV_FOCAL_Y: regs.inv_focal_y      = i_cfg_data[23:0];
                    CFG_INV_DSCALE:  regs.inv_depth_scale  = i_cfg_data[23:0];
                    CFG_POSE_QUAT:   regs.pose_quaternion  = i_cfg_data;
                    CFG_POSE_TRANS:  regs.pose_translation = i_cfg_data[62:0];
                    CFG_IMAGE_WIDTH: regs.image_width      = i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
        o_pending = points_due.size();
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Top of the depth pixel to world point testbench: clock, reset, pixel and config
// stimulus, output stall pattern and verdict. Depends on dpw_pkg, dpw_checker and the block.
`default_nettype none

module tb;
    import dpw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_pix_in              in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_point_out           out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    int                   errors;
    int                   pending;
    int                   tx_pct;
    int                   rx_pct;
    int                   rx_hold;

    depth_pixel_to_world_point_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dpw_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (rx_hold > 0) begin
            out_stall = 1'b1;
            rx_hold--;
        end else begin
            out_stall = ($urandom_range(0, 99) < rx_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("depth_pixel_to_world_point_top test failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [23:0] fx, input logic [23:0] fy,
                             input logic [23:0] ds, input logic [63:0] q,
                             input logic [62:0] t, input logic [12:0] w);
        write_reg(CFG_CENTER_X, 64'(cx));
        write_reg(CFG_CENTER_Y, 64'(cy));
        write_reg(CFG_INV_FOCAL_X, 64'(fx));
        write_reg(CFG_INV_FOCAL_Y, 64'(fy));
        write_reg(CFG_INV_DSCALE, 64'(ds));
        write_reg(CFG_POSE_QUAT, q);
        write_reg(CFG_POSE_TRANS, 64'(t));
        write_reg(CFG_IMAGE_WIDTH, 64'(w));
    endtask

    task automatic send_pixel(input logic [15:0] d, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b, input logic fs);
        while ($urandom_range(0, 99) < tx_pct) @(negedge clk);
        in_valid = 1'b1;
        in_data  = '{depth_raw: d, red: r, green: g, blue: b, frame_start: fs};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random_pixel();
        logic [15:0] d;
        case ($urandom_range(0, 9))
            0, 1:    d = 16'd0;
            2:       d = 16'($urandom_range(1, 8));
            3:       d = 16'($urandom_range(65500, 65535));
            default: d = 16'($urandom);
        endcase
        send_pixel(d, 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(0, 19) == 0);
    endtask

    // wait until the checker has no predicted point pending, then keep idling
    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (64) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_quat();
        logic [15:0] w;
        logic [15:0] a;
        logic [15:0] b;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return {16'h4000, 48'h0};
            default: begin
                w = 16'($urandom_range(0, 16384));
                a = 16'($signed(16'($urandom_range(0, 16000))) - 16'sd8000);
                b = 16'($signed(16'($urandom_range(0, 16000))) - 16'sd8000);
                return {w, a, b, 16'($urandom)};
            end
        endcase
    endfunction

    task automatic random_config();
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] ds;
        logic [12:0] w;
        fx = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000));
        fy = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000));
        ds = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 100000));
        w  = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(1, 48));
        write_all(16'($urandom), 16'($urandom), fx, fy, ds, rand_quat(),
                  63'({$urandom, $urandom}), w);
    endtask

    initial begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        out_stall = 1'b0;
        tx_pct    = 0;
        rx_pct    = 0;
        rx_hold   = 0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, field extremes, zero depth, frame restart
        send_pixel(16'd0, 8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(16'd1, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(16'hffff, 8'hff, 8'h00, 8'haa, 1'b0);
        send_pixel(16'd1000, 8'h55, 8'hff, 8'h00, 1'b1);
        send_pixel(16'h8000, 8'h01, 8'h80, 8'hfe, 1'b0);
        wait_idle();
        // zero reciprocals and centers, width zero
        write_all(16'h0, 16'h0, 24'h0, 24'h0, 24'h0, 64'h0, 63'h0, 13'd0);
        send_pixel(16'hffff, 8'h12, 8'h34, 8'h56, 1'b1);
        send_pixel(16'd7, 8'h9a, 8'hbc, 8'hde, 1'b0);
        wait_idle();
        // all ones: saturation, non-unit quaternion, width above the maximum
        write_all(16'hffff, 16'hffff, 24'hffffff, 24'hffffff, 24'hffffff,
                  64'hffff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_ffff, 13'h1fff);
        send_pixel(16'hffff, 8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(16'd1, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(16'hffff, 8'h0f, 8'hf0, 8'h3c, 1'b0);
        wait_idle();
        write_all(16'h0, 16'hffff, 24'd1, 24'hffffff, 24'd1,
                  64'h7fff_8000_7fff_8000, 63'h4000_0200_0010_0000, 13'd4096);
        send_pixel(16'hffff, 8'h11, 8'h22, 8'h33, 1'b1);
        send_pixel(16'h00ff, 8'h44, 8'h55, 8'h66, 1'b0);
        wait_idle();
        // width 4097 and width 1
        write_all(16'd5208, 16'd4056, 24'd32389, 24'd32326, 24'd16777,
                  {16'h4000, 48'h0}, 63'h0, 13'd4097);
        send_pixel(16'd500, 8'h01, 8'h02, 8'h03, 1'b1);
        send_pixel(16'd500, 8'h04, 8'h05, 8'h06, 1'b0);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 64'd1);
        send_pixel(16'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        for (int i = 1; i < 8; i++) begin
            send_pixel((i % 2 == 0) ? 16'($urandom_range(1, 65535)) : 16'd0,
                       8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        end
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                tx_pct = 17;
                rx_pct = 61;
            end else if (ph < 4) begin
                tx_pct = 61;
                rx_pct = 17;
            end else begin
                tx_pct = 0;
                rx_pct = 0;
            end
            random_config();
            if (ph == 1 || ph == 4) rx_hold = 300;
            for (int n = 0; n < 90; n++) begin
                if (ph == 3 && n == 45) wait_idle();
                send_random_pixel();
            end
            wait_idle();
        end
        rx_pct = 0;
        wait_idle();

        if (errors == 0) begin
            $display("depth_pixel_to_world_point_top test passed");
        end else begin
            $display("depth_pixel_to_world_point_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> depth_pixel_to_world_point_top.f
hdl/dpw_pkg.sv
hdl/dpw_fifo.sv
hdl/dpw_front.sv
hdl/dpw_back.sv
hdl/depth_pixel_to_world_point_top.sv
tb/dpw_checker.sv
tb/tb.sv
